// ===== src/rbe_pkg.sv =====
`default_nettype none

package rbe_pkg;

  localparam int REG_COUNT   = 32;
  localparam int REG_IDX_W   = $clog2(REG_COUNT);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [5:0] OP_MOV_REG = 6'h00;
  localparam logic [5:0] OP_ADD_REG = 6'h01;
  localparam logic [5:0] OP_SUB     = 6'h02;
  localparam logic [5:0] OP_CMP_REG = 6'h03;
  localparam logic [5:0] OP_JMP     = 6'h06;
  localparam logic [5:0] OP_MOV_IMM = 6'h10;
  localparam logic [5:0] OP_ADD_IMM = 6'h11;
  localparam logic [5:0] OP_CMP_IMM = 6'h13;
  localparam logic [5:0] OP_MOVEA   = 6'h28;
  localparam logic [5:0] OP_ADDI    = 6'h29;
  localparam logic [5:0] OP_JR      = 6'h2A;
  localparam logic [5:0] OP_JAL     = 6'h2B;
  localparam logic [5:0] OP_MOVHI   = 6'h2F;
  localparam logic [2:0] OP_BCOND_GROUP = 3'b100;

  localparam logic [REG_IDX_W-1:0] LINK_REG = REG_IDX_W'(31);
  localparam logic [31:0] RESET_PC = 32'hFFFF_FFF0;
  localparam logic [31:0] SHORT_STEP = 32'd2;
  localparam logic [31:0] LONG_STEP  = 32'd4;

  // execution classes handed from decode to execute
  localparam logic [3:0] KIND_MOVE  = 4'd0;
  localparam logic [3:0] KIND_ADD   = 4'd1;
  localparam logic [3:0] KIND_SUB   = 4'd2;
  localparam logic [3:0] KIND_CMP   = 4'd3;
  localparam logic [3:0] KIND_BCOND = 4'd4;
  localparam logic [3:0] KIND_JMP   = 4'd5;
  localparam logic [3:0] KIND_JREL  = 4'd6;
  localparam logic [3:0] KIND_JAL   = 4'd7;
  localparam logic [3:0] KIND_UNSUP = 4'd8;

  // condition codes, low three bits; bit 3 inverts
  localparam logic [2:0] CC_V  = 3'd0;
  localparam logic [2:0] CC_C  = 3'd1;
  localparam logic [2:0] CC_Z  = 3'd2;
  localparam logic [2:0] CC_NH = 3'd3;
  localparam logic [2:0] CC_N  = 3'd4;
  localparam logic [2:0] CC_T  = 3'd5;
  localparam logic [2:0] CC_LT = 3'd6;
  localparam logic [2:0] CC_LE = 3'd7;

  localparam int FLAG_Z  = 0;
  localparam int FLAG_S  = 1;
  localparam int FLAG_OV = 2;
  localparam int FLAG_CY = 3;

  typedef struct packed {
    logic [15:0] first_halfword;
    logic [15:0] second_halfword;
  } instr_t;

  typedef struct packed {
    logic [31:0]          next_pc;
    logic                 write_enable;
    logic [REG_IDX_W-1:0] write_index;
    logic [31:0]          write_value;
    logic [3:0]           flag_bits;
    logic                 branch_taken;
    logic                 unsupported;
  } result_t;

  typedef struct packed {
    logic [3:0]           kind;
    logic [REG_IDX_W-1:0] ra;
    logic [REG_IDX_W-1:0] rb;
    logic                 b_is_reg;
    logic [31:0]          imm;
    logic [3:0]           cond;
    logic                 long_form;
    logic [REG_IDX_W-1:0] wr_idx;
  } decoded_t;

endpackage

`default_nettype wire

// ===== src/rbe_ram.sv =====
`default_nettype none

module rbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== src/rbe_front.sv =====
`default_nettype none

module rbe_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             instr_valid,
  output logic                  instr_ready,
  input  wire rbe_pkg::instr_t  instr,
  output logic                  head_valid,
  output rbe_pkg::decoded_t     head,
  input  wire logic             pop
);

  rbe_pkg::decoded_t dec;
  rbe_pkg::decoded_t entries [rbe_pkg::QUEUE_DEPTH];
  logic [rbe_pkg::QPTR_W-1:0] wr_ptr;
  logic [rbe_pkg::QPTR_W-1:0] rd_ptr;
  logic [rbe_pkg::QCNT_W-1:0] count;
  logic push;
  logic take;

  logic [15:0] h1;
  logic [15:0] h2;
  logic [5:0]  op;
  logic [31:0] imm5;
  logic [31:0] imm16;

  assign h1    = instr.first_halfword;
  assign h2    = instr.second_halfword;
  assign op    = h1[15:10];
  assign imm5  = {{27{h1[4]}}, h1[4:0]};
  assign imm16 = {{16{h2[15]}}, h2};

  always_comb begin
    dec           = '0;
    dec.kind      = rbe_pkg::KIND_UNSUP;
    dec.wr_idx    = h1[9:5];
    dec.cond      = h1[12:9];
    if (op[5:3] == rbe_pkg::OP_BCOND_GROUP) begin
      dec.kind = rbe_pkg::KIND_BCOND;
      dec.imm  = {{23{h1[8]}}, h1[8:0]};
    end else begin
      unique case (op)
        rbe_pkg::OP_MOV_IMM: begin
          dec.kind = rbe_pkg::KIND_MOVE;
          dec.imm  = imm5;
        end
        rbe_pkg::OP_MOV_REG: begin
          dec.kind = rbe_pkg::KIND_MOVE;
          dec.ra   = h1[4:0];
        end
        rbe_pkg::OP_MOVEA: begin
          dec.kind      = rbe_pkg::KIND_MOVE;
          dec.ra        = h1[4:0];
          dec.imm       = imm16;
          dec.long_form = 1'b1;
        end
        rbe_pkg::OP_MOVHI: begin
          dec.kind      = rbe_pkg::KIND_MOVE;
          dec.ra        = h1[4:0];
          dec.imm       = {h2, 16'h0000};
          dec.long_form = 1'b1;
        end
        rbe_pkg::OP_ADD_IMM: begin
          dec.kind = rbe_pkg::KIND_ADD;
          dec.ra   = h1[9:5];
          dec.imm  = imm5;
        end
        rbe_pkg::OP_ADD_REG: begin
          dec.kind     = rbe_pkg::KIND_ADD;
          dec.ra       = h1[9:5];
          dec.rb       = h1[4:0];
          dec.b_is_reg = 1'b1;
        end
        rbe_pkg::OP_ADDI: begin
          dec.kind      = rbe_pkg::KIND_ADD;
          dec.ra        = h1[4:0];
          dec.imm       = imm16;
          dec.long_form = 1'b1;
        end
        rbe_pkg::OP_CMP_IMM: begin
          dec.kind = rbe_pkg::KIND_CMP;
          dec.ra   = h1[9:5];
          dec.imm  = imm5;
        end
        rbe_pkg::OP_CMP_REG: begin
          dec.kind     = rbe_pkg::KIND_CMP;
          dec.ra       = h1[9:5];
          dec.rb       = h1[4:0];
          dec.b_is_reg = 1'b1;
        end
        rbe_pkg::OP_SUB: begin
          dec.kind     = rbe_pkg::KIND_SUB;
          dec.ra       = h1[9:5];
          dec.rb       = h1[4:0];
          dec.b_is_reg = 1'b1;
        end
        rbe_pkg::OP_JMP: begin
          dec.kind = rbe_pkg::KIND_JMP;
          dec.ra   = h1[4:0];
        end
        rbe_pkg::OP_JR: begin
          dec.kind      = rbe_pkg::KIND_JREL;
          dec.imm       = {{6{h1[9]}}, h1[9:0], h2};
          dec.long_form = 1'b1;
        end
        rbe_pkg::OP_JAL: begin
          dec.kind      = rbe_pkg::KIND_JAL;
          dec.imm       = {{6{h1[9]}}, h1[9:0], h2};
          dec.long_form = 1'b1;
          dec.wr_idx    = rbe_pkg::LINK_REG;
        end
        default: begin
          dec.kind = rbe_pkg::KIND_UNSUP;
        end
      endcase
    end
  end

  assign instr_ready = (count != rbe_pkg::QCNT_W'(rbe_pkg::QUEUE_DEPTH));
  assign head_valid  = (count != '0);
  assign head        = entries[rd_ptr];
  assign push        = instr_valid && instr_ready;
  assign take        = head_valid && pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= dec;
        wr_ptr <= (wr_ptr == rbe_pkg::QPTR_W'(rbe_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == rbe_pkg::QPTR_W'(rbe_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/rbe_back.sv =====
`default_nettype none

module rbe_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire rbe_pkg::decoded_t head,
  output logic                   pop,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output rbe_pkg::result_t       result
);

  localparam int IW = rbe_pkg::REG_IDX_W;

  logic              x_valid;
  rbe_pkg::decoded_t x;
  logic              x_fire;
  logic              x_load;

  logic [31:0]          pc;
  logic [3:0]           flags;
  logic [rbe_pkg::REG_COUNT-1:0] reg_valid;
  logic                 lw_en;
  logic [IW-1:0]        lw_idx;
  logic [31:0]          lw_val;

  logic [IW-1:0] raddr_a;
  logic [IW-1:0] raddr_b;
  logic [31:0]   rdata_a;
  logic [31:0]   rdata_b;

  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] reg_b;
  logic [32:0] sum;
  logic [32:0] diff;
  logic [31:0] seq_pc;
  logic [31:0] rel_pc;
  logic        cond_base;
  logic        cond_ok;

  logic [31:0] npc;
  logic [3:0]  flags_next;
  logic        wr;
  logic        we;
  logic [31:0] wval;
  logic        taken;
  logic        unsup;

  assign x_fire = x_valid && (!result_valid || result_ready);
  assign x_load = !x_valid || x_fire;
  assign pop    = x_load;

  // keep reading the held item's operands while execute is stalled
  assign raddr_a = x_load ? head.ra : x.ra;
  assign raddr_b = x_load ? head.rb : x.rb;

  rbe_ram #(
    .WIDTH(32),
    .DEPTH(rbe_pkg::REG_COUNT)
  ) u_regs (
    .clk    (clk),
    .we     (x_fire && we),
    .waddr  (x.wr_idx),
    .wdata  (wval),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  // bypass the write that lands on the same edge as the read
  always_comb begin
    if (x.ra == '0) begin
      op_a = '0;
    end else if (lw_en && (lw_idx == x.ra)) begin
      op_a = lw_val;
    end else if (reg_valid[x.ra]) begin
      op_a = rdata_a;
    end else begin
      op_a = '0;
    end
    if (x.rb == '0) begin
      reg_b = '0;
    end else if (lw_en && (lw_idx == x.rb)) begin
      reg_b = lw_val;
    end else if (reg_valid[x.rb]) begin
      reg_b = rdata_b;
    end else begin
      reg_b = '0;
    end
  end

  assign op_b   = x.b_is_reg ? reg_b : x.imm;
  assign sum    = {1'b0, op_a} + {1'b0, op_b};
  assign diff   = {1'b0, op_a} - {1'b0, op_b};
  assign seq_pc = pc + (x.long_form ? rbe_pkg::LONG_STEP : rbe_pkg::SHORT_STEP);
  assign rel_pc = pc + x.imm;

  always_comb begin
    case (x.cond[2:0])
      rbe_pkg::CC_V:  cond_base = flags[rbe_pkg::FLAG_OV];
      rbe_pkg::CC_C:  cond_base = flags[rbe_pkg::FLAG_CY];
      rbe_pkg::CC_Z:  cond_base = flags[rbe_pkg::FLAG_Z];
      rbe_pkg::CC_NH: cond_base = flags[rbe_pkg::FLAG_CY] || flags[rbe_pkg::FLAG_Z];
      rbe_pkg::CC_N:  cond_base = flags[rbe_pkg::FLAG_S];
      rbe_pkg::CC_T:  cond_base = 1'b1;
      rbe_pkg::CC_LT: cond_base = flags[rbe_pkg::FLAG_S] ^ flags[rbe_pkg::FLAG_OV];
      rbe_pkg::CC_LE: cond_base = (flags[rbe_pkg::FLAG_S] ^ flags[rbe_pkg::FLAG_OV])
                                  || flags[rbe_pkg::FLAG_Z];
      default:        cond_base = 1'b0;
    endcase
  end

  assign cond_ok = x.cond[3] ? !cond_base : cond_base;

  always_comb begin
    npc        = seq_pc;
    flags_next = flags;
    wr         = 1'b0;
    wval       = '0;
    taken      = 1'b0;
    unsup      = 1'b0;
    unique case (x.kind) inside
      rbe_pkg::KIND_MOVE: begin
        wr   = 1'b1;
        wval = sum[31:0];
      end
      rbe_pkg::KIND_ADD: begin
        wr   = 1'b1;
        wval = sum[31:0];
        flags_next[rbe_pkg::FLAG_Z]  = (sum[31:0] == '0);
        flags_next[rbe_pkg::FLAG_S]  = sum[31];
        flags_next[rbe_pkg::FLAG_OV] = ~(op_a[31] ^ op_b[31]) & (op_a[31] ^ sum[31]);
        flags_next[rbe_pkg::FLAG_CY] = sum[32];
      end
      rbe_pkg::KIND_SUB, rbe_pkg::KIND_CMP: begin
        wr   = (x.kind == rbe_pkg::KIND_SUB);
        wval = diff[31:0];
        flags_next[rbe_pkg::FLAG_Z]  = (diff[31:0] == '0);
        flags_next[rbe_pkg::FLAG_S]  = diff[31];
        flags_next[rbe_pkg::FLAG_OV] = (op_a[31] ^ op_b[31]) & (op_a[31] ^ diff[31]);
        flags_next[rbe_pkg::FLAG_CY] = diff[32];
      end
      rbe_pkg::KIND_BCOND: begin
        if (cond_ok) begin
          npc   = {rel_pc[31:1], 1'b0};
          taken = 1'b1;
        end
      end
      rbe_pkg::KIND_JMP: begin
        npc   = {op_a[31:1], 1'b0};
        taken = 1'b1;
      end
      rbe_pkg::KIND_JREL: begin
        npc   = {rel_pc[31:1], 1'b0};
        taken = 1'b1;
      end
      rbe_pkg::KIND_JAL: begin
        wr    = 1'b1;
        wval  = seq_pc;
        npc   = {rel_pc[31:1], 1'b0};
        taken = 1'b1;
      end
      default: begin
        unsup = 1'b1;
        npc   = pc;
      end
    endcase
  end

  // writes to r0 are dropped
  assign we = wr && (x.wr_idx != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid      <= 1'b0;
      result_valid <= 1'b0;
      pc           <= rbe_pkg::RESET_PC;
      flags        <= '0;
      reg_valid    <= '0;
      lw_en        <= 1'b0;
    end else begin
      if (x_load) begin
        x_valid <= head_valid;
        x       <= head;
      end
      if (x_fire) begin
        pc           <= npc;
        flags        <= flags_next;
        result_valid <= 1'b1;
        result.next_pc      <= npc;
        result.write_enable <= we;
        result.write_index  <= we ? x.wr_idx : '0;
        result.write_value  <= we ? wval : '0;
        result.flag_bits    <= flags_next;
        result.branch_taken <= taken;
        result.unsupported  <= unsup;
        if (we) begin
          reg_valid[x.wr_idx] <= 1'b1;
          lw_en  <= 1'b1;
          lw_idx <= x.wr_idx;
          lw_val <= wval;
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/risc_integer_branch_execute_unit.sv =====
// Integer and branch execute unit of a small 32-bit RISC core.
// The instr channel takes one fetched instruction per request: the first
// halfword and, for the 32-bit formats, the second halfword (ignored by
// 16-bit forms). The result channel returns one record per instruction:
// next PC, register write, flags, branch taken and an unsupported mark.
// Both channels use valid/ready; a request is taken when both are high.
// A request moves from the decode queue to execute to the result register.
// Throughput: one instruction per cycle while results are taken; the
// register read ports and the single execute stage set that figure, with
// the last write bypassed so dependent instructions issue back to back.
// A two-entry decode queue sits between decode and execute, and a result
// register sits at the output, so requests keep flowing into the queue
// while a result waits; when the receiver stalls, execute holds and the
// queue fills, then instr_ready drops.
// Reset (synchronous, active high) empties the queue and pipeline, sets
// the PC to 0xFFFFFFF0, clears the flags and marks every register as zero.
`default_nettype none

module risc_integer_branch_execute_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            instr_valid,
  output logic                 instr_ready,
  input  wire rbe_pkg::instr_t instr,
  output logic                 result_valid,
  input  wire logic            result_ready,
  output rbe_pkg::result_t     result
);

  logic              head_valid;
  rbe_pkg::decoded_t head;
  logic              pop;

  rbe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .instr_valid(instr_valid),
    .instr_ready(instr_ready),
    .instr      (instr),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  rbe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

`default_nettype wire

// ===== verif/risc_integer_branch_execute_unit_tb.sv =====
`timescale 1ns / 1ps

module risc_integer_branch_execute_unit_tb;

  localparam int LONG_STALL_CYCLES = 200;
  localparam int TAIL_CYCLES       = 10;

  logic             clk;
  logic             rst;
  logic             instr_valid;
  logic             instr_ready;
  rbe_pkg::instr_t  instr;
  logic             result_valid;
  logic             result_ready;
  rbe_pkg::result_t result;

  // architectural state of the predictor
  logic [31:0] gpr [rbe_pkg::REG_COUNT];
  logic [31:0] cur_pc;
  logic [3:0]  cur_flags;

  rbe_pkg::result_t expected_results [$];
  int      fail_count = 0;
  bit      idle_off = 1'b0;
  bit      long_stall_req = 1'b0;

  risc_integer_branch_execute_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_ready  (instr_ready),
    .instr        (instr),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int idle_gap();
    int r;
    if (idle_off) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] reg_read(logic [4:0] idx);
    return (idx == 5'd0) ? 32'd0 : gpr[idx];
  endfunction

  function automatic logic [31:0] add_with_flags(logic [31:0] a, logic [31:0] b);
    logic [32:0] sum;
    logic [31:0] r;
    sum = {1'b0, a} + {1'b0, b};
    r = sum[31:0];
    cur_flags[rbe_pkg::FLAG_Z]  = (r == 32'd0);
    cur_flags[rbe_pkg::FLAG_S]  = r[31];
    cur_flags[rbe_pkg::FLAG_OV] = ~(a[31] ^ b[31]) & (a[31] ^ r[31]);
    cur_flags[rbe_pkg::FLAG_CY] = sum[32];
    return r;
  endfunction

  function automatic logic [31:0] sub_with_flags(logic [31:0] a, logic [31:0] b);
    logic [31:0] r;
    r = a - b;
    cur_flags[rbe_pkg::FLAG_Z]  = (r == 32'd0);
    cur_flags[rbe_pkg::FLAG_S]  = r[31];
    cur_flags[rbe_pkg::FLAG_OV] = (a[31] ^ b[31]) & (a[31] ^ r[31]);
    cur_flags[rbe_pkg::FLAG_CY] = (a < b);
    return r;
  endfunction

  function automatic bit cond_holds(logic [3:0] c);
    logic z, s, ov, cy;
    bit   base;
    z  = cur_flags[rbe_pkg::FLAG_Z];
    s  = cur_flags[rbe_pkg::FLAG_S];
    ov = cur_flags[rbe_pkg::FLAG_OV];
    cy = cur_flags[rbe_pkg::FLAG_CY];
    case (c[2:0])
      rbe_pkg::CC_V:  base = ov;
      rbe_pkg::CC_C:  base = cy;
      rbe_pkg::CC_Z:  base = z;
      rbe_pkg::CC_NH: base = cy | z;
      rbe_pkg::CC_N:  base = s;
      rbe_pkg::CC_T:  base = 1'b1;
      rbe_pkg::CC_LT: base = s ^ ov;
      rbe_pkg::CC_LE: base = (s ^ ov) | z;
    endcase
    return c[3] ? !base : base;
  endfunction

  // Execute one instruction against the predictor state and return its record.
  function automatic rbe_pkg::result_t retire_instr(rbe_pkg::instr_t item);
    rbe_pkg::result_t res;
    logic [15:0] fh;
    logic [5:0]  op;
    logic [4:0]  src, dst, widx;
    logic [31:0] pc, npc, wval, simm16, simm5, disp;
    logic        wr, taken, unsup;
    fh     = item.first_halfword;
    op     = fh[15:10];
    dst    = fh[9:5];
    src    = fh[4:0];
    simm16 = {{16{item.second_halfword[15]}}, item.second_halfword};
    simm5  = {{27{src[4]}}, src};
    pc     = cur_pc;
    npc    = pc + rbe_pkg::SHORT_STEP;
    wr     = 1'b0;
    taken  = 1'b0;
    unsup  = 1'b0;
    widx   = dst;
    wval   = 32'd0;
    if (op[5:3] == rbe_pkg::OP_BCOND_GROUP) begin
      if (cond_holds(fh[12:9])) begin
        npc   = pc + {{23{fh[8]}}, fh[8:0]};
        npc   = {npc[31:1], 1'b0};
        taken = 1'b1;
      end
    end else begin
      case (op) inside
        rbe_pkg::OP_MOV_IMM: begin wr = 1'b1; wval = simm5; end
        rbe_pkg::OP_MOV_REG: begin wr = 1'b1; wval = reg_read(src); end
        rbe_pkg::OP_MOVEA: begin
          wr = 1'b1; wval = reg_read(src) + simm16; npc = pc + rbe_pkg::LONG_STEP;
        end
        rbe_pkg::OP_MOVHI: begin
          wr = 1'b1; wval = reg_read(src) + {item.second_halfword, 16'd0};
          npc = pc + rbe_pkg::LONG_STEP;
        end
        rbe_pkg::OP_ADD_IMM: begin
          wr = 1'b1; wval = add_with_flags(reg_read(dst), simm5);
        end
        rbe_pkg::OP_ADD_REG: begin
          wr = 1'b1; wval = add_with_flags(reg_read(dst), reg_read(src));
        end
        rbe_pkg::OP_ADDI: begin
          wr = 1'b1; wval = add_with_flags(reg_read(src), simm16);
          npc = pc + rbe_pkg::LONG_STEP;
        end
        rbe_pkg::OP_CMP_IMM: void'(sub_with_flags(reg_read(dst), simm5));
        rbe_pkg::OP_CMP_REG: void'(sub_with_flags(reg_read(dst), reg_read(src)));
        rbe_pkg::OP_SUB: begin
          wr = 1'b1; wval = sub_with_flags(reg_read(dst), reg_read(src));
        end
        rbe_pkg::OP_JMP: begin
          npc = reg_read(src); npc[0] = 1'b0; taken = 1'b1;
        end
        rbe_pkg::OP_JR, rbe_pkg::OP_JAL: begin
          disp = {{6{fh[9]}}, fh[9:0], item.second_halfword};
          if (op == rbe_pkg::OP_JAL) begin
            wr = 1'b1; widx = rbe_pkg::LINK_REG; wval = pc + rbe_pkg::LONG_STEP;
          end
          npc = pc + disp;
          npc[0] = 1'b0;
          taken = 1'b1;
        end
        default: begin unsup = 1'b1; npc = pc; end
      endcase
    end
    // drop writes to register zero
    if (wr && widx == 5'd0) wr = 1'b0;
    if (wr) gpr[widx] = wval;
    else begin
      widx = 5'd0;
      wval = 32'd0;
    end
    cur_pc = npc;
    res.next_pc      = npc;
    res.write_enable = wr;
    res.write_index  = widx;
    res.write_value  = wval;
    res.flag_bits    = cur_flags;
    res.branch_taken = taken;
    res.unsupported  = unsup;
    return res;
  endfunction

  function automatic rbe_pkg::instr_t enc_regs(logic [5:0] op, logic [4:0] dst,
                                               logic [4:0] src, logic [15:0] tail);
    return {op, dst, src, tail};
  endfunction

  function automatic rbe_pkg::instr_t enc_bcond(logic [3:0] cond, logic [8:0] disp);
    return {rbe_pkg::OP_BCOND_GROUP, cond, disp, 16'($urandom)};
  endfunction

  function automatic rbe_pkg::instr_t enc_jump(logic [5:0] op, logic [25:0] disp);
    return {op, disp};
  endfunction

  function automatic rbe_pkg::instr_t random_instr();
    logic [15:0] tail;
    logic [4:0]  d, s;
    tail = 16'($urandom);
    d    = 5'($urandom);
    s    = 5'($urandom);
    case ($urandom_range(0, 19)) inside
      0:  return enc_regs(rbe_pkg::OP_MOV_REG, d, s, tail);
      1:  return enc_regs(rbe_pkg::OP_ADD_REG, d, s, tail);
      2:  return enc_regs(rbe_pkg::OP_SUB, d, s, tail);
      3:  return enc_regs(rbe_pkg::OP_CMP_REG, d, s, tail);
      4:  return enc_regs(rbe_pkg::OP_JMP, d, s, tail);
      5:  return enc_regs(rbe_pkg::OP_MOV_IMM, d, s, tail);
      6:  return enc_regs(rbe_pkg::OP_ADD_IMM, d, s, tail);
      7:  return enc_regs(rbe_pkg::OP_CMP_IMM, d, s, tail);
      8:  return enc_regs(rbe_pkg::OP_MOVEA, d, s, tail);
      9:  return enc_regs(rbe_pkg::OP_ADDI, d, s, tail);
      10: return enc_regs(rbe_pkg::OP_MOVHI, d, s, tail);
      11: return enc_jump(rbe_pkg::OP_JR, 26'($urandom));
      12: return enc_jump(rbe_pkg::OP_JAL, 26'($urandom));
      [13:16]: return enc_bcond(4'($urandom), 9'($urandom));
      default: return {16'($urandom), tail};
    endcase
  endfunction

  // Offer one request, hold it until taken, then record what it should produce.
  task automatic send_instr(input rbe_pkg::instr_t item);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      instr_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_valid <= 1'b1;
    instr       <= item;
    do @(posedge clk); while (!instr_ready);
    expected_results.push_back(retire_instr(item));
  endtask

  task automatic wait_for_results();
    instr_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_instr(enc_regs(rbe_pkg::OP_MOV_IMM, 5'd1, 5'h10, 16'hFFFF));   // most negative imm5
    send_instr(enc_regs(rbe_pkg::OP_MOV_IMM, 5'd2, 5'h0F, 16'h0000));   // most positive imm5
    send_instr(enc_regs(rbe_pkg::OP_MOV_IMM, 5'd0, 5'h1F, 16'h5A5A));   // write to r0 dropped
    send_instr(enc_regs(rbe_pkg::OP_MOVHI, 5'd3, 5'd0, 16'hFFFF));
    send_instr(enc_regs(rbe_pkg::OP_MOVEA, 5'd3, 5'd3, 16'hFFFF));
    send_instr(enc_regs(rbe_pkg::OP_MOVHI, 5'd4, 5'd0, 16'h7FFF));
    send_instr(enc_regs(rbe_pkg::OP_MOVEA, 5'd4, 5'd4, 16'h7FFF));
    send_instr(enc_regs(rbe_pkg::OP_ADD_REG, 5'd4, 5'd4, 16'h1234)); // signed overflow
    send_instr(enc_regs(rbe_pkg::OP_ADDI, 5'd5, 5'd3, 16'h8000));    // carry out
    send_instr(enc_regs(rbe_pkg::OP_ADD_IMM, 5'd1, 5'h10, 16'h0000));
    send_instr(enc_regs(rbe_pkg::OP_SUB, 5'd2, 5'd1, 16'hFFFF));     // borrow
    send_instr(enc_regs(rbe_pkg::OP_CMP_REG, 5'd2, 5'd2, 16'h0000)); // zero
    send_instr(enc_regs(rbe_pkg::OP_CMP_IMM, 5'd0, 5'h01, 16'hFFFF));
    send_instr(enc_regs(rbe_pkg::OP_SUB, 5'd0, 5'd3, 16'h0000));     // flags only
    send_instr(enc_regs(rbe_pkg::OP_MOV_REG, 5'd6, 5'd4, 16'hFFFF));
    send_instr(enc_bcond(4'hF, 9'h1FE));
    send_instr(enc_bcond(4'hD, 9'h0FF));
    send_instr(enc_bcond(4'h5, 9'h100));
    send_instr(enc_bcond(4'h6, 9'h004));
    send_instr(enc_jump(rbe_pkg::OP_JR, 26'h3FF_FFFE));
    send_instr(enc_jump(rbe_pkg::OP_JAL, 26'h1FF_FFFF));
    send_instr(enc_regs(rbe_pkg::OP_JMP, 5'd0, 5'd31, 16'hFFFF));
    send_instr(enc_regs(rbe_pkg::OP_MOV_IMM, 5'd31, 5'h00, 16'h0000));
    send_instr(enc_regs(6'h3F, 5'h1F, 5'h1F, 16'hFFFF));     // unsupported
    send_instr(enc_regs(6'h07, 5'h00, 5'h00, 16'h0000));     // unsupported
  endtask

  task automatic test_back_to_back();
    idle_off = 1'b1;
    repeat (100) send_instr(random_instr());
    idle_off = 1'b0;
  endtask

  task automatic test_output_backpressure();
    idle_off = 1'b1;
    long_stall_req = 1'b1;
    repeat (40) send_instr(random_instr());
    idle_off = 1'b0;
  endtask

  task automatic test_pause_for_drain();
    repeat (20) send_instr(random_instr());
    wait_for_results();
    repeat (20) send_instr(random_instr());
  endtask

  task automatic test_random_mix();
    repeat (850) send_instr(random_instr());
  endtask

  initial begin : result_sink
    int span;
    int burst;
    burst = 0;
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        result_ready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
        result_ready <= 1'b1;
      end else if (idle_off || burst > 0) begin
        if (burst > 0) burst--;
        result_ready <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        span = idle_gap() + 1;
        result_ready <= 1'b0;
        repeat (span) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        burst = $urandom_range(0, 15);
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    rbe_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: %h", result);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (result.next_pc !== want.next_pc) begin
          $error("next_pc expected %h actual %h", want.next_pc, result.next_pc);
          fail_count++;
        end
        if (result.write_enable !== want.write_enable) begin
          $error("write_enable expected %b actual %b", want.write_enable, result.write_enable);
          fail_count++;
        end
        if (result.write_index !== want.write_index) begin
          $error("write_index expected %0d actual %0d", want.write_index, result.write_index);
          fail_count++;
        end
        if (result.write_value !== want.write_value) begin
          $error("write_value expected %h actual %h", want.write_value, result.write_value);
          fail_count++;
        end
        if (result.flag_bits !== want.flag_bits) begin
          $error("flag_bits expected %b actual %b", want.flag_bits, result.flag_bits);
          fail_count++;
        end
        if (result.branch_taken !== want.branch_taken) begin
          $error("branch_taken expected %b actual %b", want.branch_taken, result.branch_taken);
          fail_count++;
        end
        if (result.unsupported !== want.unsupported) begin
          $error("unsupported expected %b actual %b", want.unsupported, result.unsupported);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst         <= 1'b1;
    instr_valid <= 1'b0;
    instr       <= '0;
    for (int i = 0; i < rbe_pkg::REG_COUNT; i++) gpr[i] = 32'd0;
    cur_pc    = rbe_pkg::RESET_PC;
    cur_flags = 4'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_back_to_back();
    test_output_backpressure();
    test_pause_for_drain();
    test_random_mix();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== risc_integer_branch_execute_unit.f =====
src/rbe_pkg.sv
src/rbe_ram.sv
src/rbe_front.sv
src/rbe_back.sv
src/risc_integer_branch_execute_unit.sv
verif/risc_integer_branch_execute_unit_tb.sv
